FILE: design/risc8_pkg.sv
// ----------------------------------------------------------------------------
// risc8_pkg
// Request codes, opcodes, instruction classes and the result item type of the
// 8-bit RISC instruction executor.
// ----------------------------------------------------------------------------
package risc8_pkg;

  localparam int NUM_REGS = 16;
  localparam int RIDX_W   = 4;

  localparam logic [1:0] REQ_EXEC        = 2'd0;
  localparam logic [1:0] REQ_PRELOAD_REG = 2'd1;
  localparam logic [1:0] REQ_PRELOAD_MEM = 2'd2;

  localparam logic [3:0] OP_ADD   = 4'b0000;
  localparam logic [3:0] OP_SUB   = 4'b0001;
  localparam logic [3:0] OP_MUL   = 4'b0010;
  localparam logic [3:0] OP_INC   = 4'b0011;
  localparam logic [3:0] OP_AND   = 4'b0100;
  localparam logic [3:0] OP_OR    = 4'b0101;
  localparam logic [3:0] OP_NOT   = 4'b0110;
  localparam logic [3:0] OP_XOR   = 4'b0111;
  localparam logic [3:0] OP_LOAD  = 4'b1000;
  localparam logic [3:0] OP_STORE = 4'b1001;
  localparam logic [3:0] OP_JMP   = 4'b1010;
  localparam logic [3:0] OP_BEQZ  = 4'b1011;
  localparam logic [3:0] OP_HALT  = 4'b1111;

  localparam logic [2:0] CLS_ARITH = 3'd0;
  localparam logic [2:0] CLS_LOGIC = 3'd1;
  localparam logic [2:0] CLS_DATA  = 3'd2;
  localparam logic [2:0] CLS_CTRL  = 3'd3;
  localparam logic [2:0] CLS_HALT  = 3'd4;
  localparam logic [2:0] CLS_NONE  = 3'd5;

  typedef struct packed {
    logic [7:0]        next_pc;
    logic              halted;
    logic [2:0]        instr_class;
    logic              reg_write_valid;
    logic [RIDX_W-1:0] reg_write_index;
    logic [7:0]        reg_write_value;
    logic              mem_write_valid;
    logic [7:0]        mem_write_addr;
    logic [7:0]        mem_write_value;
  } result_t;

  function automatic logic [7:0] sext4_to8(input logic [3:0] v);
    return {{4{v[3]}}, v};
  endfunction

endpackage

FILE: design/risc8_ram.sv
// ----------------------------------------------------------------------------
// risc8_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module risc8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/eight_bit_risc_instruction_executor.sv
// ----------------------------------------------------------------------------
// eight_bit_risc_instruction_executor
// A result item passes the execute register and then the output register; a load also passes the load return stage.
// Accepts one item per cycle while the output is not stalled; a load holds the input
//   while its byte comes back from the data memory read port and is written.
// Register file reads are registered; a write in the accept cycle is forwarded.
// Reset clears pc, halt flag and all valid flags; registers and data memory
//   are not initialized.
// ----------------------------------------------------------------------------
module eight_bit_risc_instruction_executor #(
  parameter int DMEM_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [15:0]                  in_instr_word,
  input  logic [7:0]                   in_preload_index,
  input  logic [7:0]                   in_preload_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_next_pc,
  output logic                         out_halted,
  output logic [2:0]                   out_instr_class,
  output logic                         out_reg_write_valid,
  output logic [risc8_pkg::RIDX_W-1:0] out_reg_write_index,
  output logic [7:0]                   out_reg_write_value,
  output logic                         out_mem_write_valid,
  output logic [7:0]                   out_mem_write_addr,
  output logic [7:0]                   out_mem_write_value
);
  import risc8_pkg::*;

  localparam int AW = $clog2(DMEM_DEPTH);

  function automatic logic [AW-1:0] dmem_wrap(input logic [7:0] a);
    logic [11:0] rem;
    rem = {4'b0000, a};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= 12'(DMEM_DEPTH << k)) begin
        rem = rem - 12'(DMEM_DEPTH << k);
      end
    end
    return rem[AW-1:0];
  endfunction

  // control state
  logic [7:0] pc_r, pc_nxt;
  logic       halt_r, halt_nxt;
  logic       x_valid_r, x_valid_nxt;
  logic       m_valid_r, m_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fwd_v_r, fwd_v_nxt;

  // payload
  logic [1:0]        x_req_r;
  logic [15:0]       x_iw_r;
  logic [7:0]        x_pidx_r;
  logic [7:0]        x_pval_r;
  logic [RIDX_W-1:0] fwd_idx_r, fwd_idx_nxt;
  logic [7:0]        fwd_val_r, fwd_val_nxt;
  logic [7:0]        m_npc_r;
  logic [RIDX_W-1:0] m_idx_r;
  result_t           out_r, out_nxt;

  logic              in_accept;
  logic              out_go;
  logic              x_load;
  logic              x_go_oth;
  logic              x_load_go;
  logic              m_go;
  result_t           x_res;
  result_t           m_res;

  logic [3:0]        op, fa, fb, fc;
  logic [7:0]        ra_q, rb_q, rc_q, ra, rb, rc;
  logic [7:0]        seq;
  logic [7:0]        prod;
  logic [AW-1:0]     eff_addr;
  logic [7:0]        dm_q;

  logic              rf_we;
  logic [RIDX_W-1:0] rf_waddr;
  logic [7:0]        rf_wdata;
  logic              dm_we;

  assign out_go    = !out_valid_r || !out_stall;
  assign in_accept = in_valid && !in_stall;

  assign op = x_iw_r[15:12];
  assign fa = x_iw_r[11:8];
  assign fb = x_iw_r[7:4];
  assign fc = x_iw_r[3:0];

  assign ra = (fwd_v_r && fwd_idx_r == fa) ? fwd_val_r : ra_q;
  assign rb = (fwd_v_r && fwd_idx_r == fb) ? fwd_val_r : rb_q;
  assign rc = (fwd_v_r && fwd_idx_r == fc) ? fwd_val_r : rc_q;

  assign seq      = pc_r + 8'd2;
  assign prod     = 8'(rb * rc);
  assign eff_addr = dmem_wrap(rb + sext4_to8(fc));

  assign x_load    = x_req_r == REQ_EXEC && !halt_r && op == OP_LOAD;
  assign x_load_go = x_valid_r && x_load;
  assign x_go_oth  = x_valid_r && !x_load && out_go;
  assign m_go      = m_valid_r && out_go;
  assign in_stall  = m_valid_r || (x_valid_r && !x_go_oth);

  always_comb begin
    x_res = '0;
    x_res.next_pc     = pc_r;
    x_res.halted      = halt_r;
    x_res.instr_class = CLS_NONE;
    unique case (x_req_r)
      REQ_PRELOAD_REG: begin
        if (x_pidx_r < 8'(NUM_REGS)) begin
          x_res.reg_write_valid = 1'b1;
          x_res.reg_write_index = x_pidx_r[RIDX_W-1:0];
          x_res.reg_write_value = x_pval_r;
        end
      end
      REQ_PRELOAD_MEM: begin
        if ({1'b0, x_pidx_r} < 9'(DMEM_DEPTH)) begin
          x_res.mem_write_valid = 1'b1;
          x_res.mem_write_addr  = x_pidx_r;
          x_res.mem_write_value = x_pval_r;
        end
      end
      REQ_EXEC: begin
        if (!halt_r) begin
          x_res.next_pc         = seq;
          x_res.reg_write_index = fa;
          unique case (op)
            OP_ADD: begin
              x_res.instr_class     = CLS_ARITH;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = rb + rc;
            end
            OP_SUB: begin
              x_res.instr_class     = CLS_ARITH;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = rb - rc;
            end
            OP_MUL: begin
              x_res.instr_class     = CLS_ARITH;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = prod;
            end
            OP_INC: begin
              x_res.instr_class     = CLS_ARITH;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = ra + 8'd1;
            end
            OP_AND: begin
              x_res.instr_class     = CLS_LOGIC;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = rb & rc;
            end
            OP_OR: begin
              x_res.instr_class     = CLS_LOGIC;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = rb | rc;
            end
            OP_NOT: begin
              x_res.instr_class     = CLS_LOGIC;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = ~rb;
            end
            OP_XOR: begin
              x_res.instr_class     = CLS_LOGIC;
              x_res.reg_write_valid = 1'b1;
              x_res.reg_write_value = rb ^ rc;
            end
            OP_LOAD: begin
              x_res.instr_class = CLS_DATA;
            end
            OP_STORE: begin
              x_res.instr_class     = CLS_DATA;
              x_res.mem_write_valid = 1'b1;
              x_res.mem_write_addr  = 8'(eff_addr);
              x_res.mem_write_value = ra;
            end
            OP_JMP: begin
              x_res.instr_class = CLS_CTRL;
              x_res.next_pc     = seq + {x_iw_r[10:4], 1'b0};
            end
            OP_BEQZ: begin
              x_res.instr_class = CLS_CTRL;
              if (ra == 8'd0) begin
                x_res.next_pc = seq + {x_iw_r[6:0], 1'b0};
              end
            end
            OP_HALT: begin
              x_res.instr_class = CLS_HALT;
              x_res.halted      = 1'b1;
            end
            default: begin
              x_res.instr_class = CLS_NONE;
            end
          endcase
          if (!x_res.reg_write_valid) begin
            x_res.reg_write_index = '0;
          end
        end
      end
      default: begin
        x_res.instr_class = CLS_NONE;
      end
    endcase
  end

  always_comb begin
    m_res = '0;
    m_res.next_pc         = m_npc_r;
    m_res.halted          = halt_r;
    m_res.instr_class     = CLS_DATA;
    m_res.reg_write_valid = 1'b1;
    m_res.reg_write_index = m_idx_r;
    m_res.reg_write_value = dm_q;
  end

  assign rf_we    = (x_go_oth && x_res.reg_write_valid) || m_go;
  assign rf_waddr = m_valid_r ? m_idx_r : x_res.reg_write_index;
  assign rf_wdata = m_valid_r ? dm_q : x_res.reg_write_value;
  assign dm_we    = x_go_oth && x_res.mem_write_valid;

  risc8_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_accept),
    .raddr (in_instr_word[11:8]),
    .rdata (ra_q)
  );

  risc8_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_accept),
    .raddr (in_instr_word[7:4]),
    .rdata (rb_q)
  );

  risc8_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_rf_c (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_accept),
    .raddr (in_instr_word[3:0]),
    .rdata (rc_q)
  );

  risc8_ram #(.WIDTH(8), .DEPTH(DMEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (x_res.mem_write_addr[AW-1:0]),
    .wdata (x_res.mem_write_value),
    .re    (x_load_go),
    .raddr (eff_addr),
    .rdata (dm_q)
  );

  always_comb begin
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    if (x_go_oth || x_load_go) begin
      pc_nxt   = x_res.next_pc;
      halt_nxt = x_res.halted;
    end
    x_valid_nxt   = in_accept || (x_valid_r && !(x_go_oth || x_load_go));
    m_valid_nxt   = x_load_go || (m_valid_r && !m_go);
    out_valid_nxt = x_go_oth || m_go || (out_valid_r && out_stall);
    // capture the write that lands on the same edge as the register read
    fwd_v_nxt     = in_accept ? rf_we : fwd_v_r;
    fwd_idx_nxt   = in_accept ? rf_waddr : fwd_idx_r;
    fwd_val_nxt   = in_accept ? rf_wdata : fwd_val_r;
    priority if (x_go_oth) begin
      out_nxt = x_res;
    end else if (m_go) begin
      out_nxt = m_res;
    end else begin
      out_nxt = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      halt_r      <= 1'b0;
      x_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_v_r     <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      x_valid_r   <= x_valid_nxt;
      m_valid_r   <= m_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_v_r     <= fwd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_req_r  <= in_req_type;
      x_iw_r   <= in_instr_word;
      x_pidx_r <= in_preload_index;
      x_pval_r <= in_preload_value;
    end
    if (x_load_go) begin
      m_npc_r <= x_res.next_pc;
      m_idx_r <= fa;
    end
    fwd_idx_r <= fwd_idx_nxt;
    fwd_val_r <= fwd_val_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_next_pc         = out_r.next_pc;
  assign out_halted          = out_r.halted;
  assign out_instr_class     = out_r.instr_class;
  assign out_reg_write_valid = out_r.reg_write_valid;
  assign out_reg_write_index = out_r.reg_write_index;
  assign out_reg_write_value = out_r.reg_write_value;
  assign out_mem_write_valid = out_r.mem_write_valid;
  assign out_mem_write_addr  = out_r.mem_write_addr;
  assign out_mem_write_value = out_r.mem_write_value;

  a_m_excl_x: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r |-> !x_valid_r)
    else $error("load return stage overlaps execute stage");

  a_load_to_m: assert property (@(posedge clk) disable iff (!rst_n)
    x_load_go |=> m_valid_r && !x_valid_r)
    else $error("load did not move to return stage");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.reg_write_valid && out_r.mem_write_valid))
    else $error("item reports register and memory write");

endmodule

FILE: tb/sv/eight_bit_risc_instruction_executor_checker.sv
// ----------------------------------------------------------------------------
// eight_bit_risc_instruction_executor_checker
// Watches both channels of the executor. Every accepted input item is retired
// against a private copy of the register file, data memory, pc and halt flag.
// The predicted retire record is queued. Each accepted result item is then
// compared field by field with the oldest queued record.
// ----------------------------------------------------------------------------
module eight_bit_risc_instruction_executor_checker #(
  parameter int DMEM_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [15:0]                  in_instr_word,
  input  logic [7:0]                   in_preload_index,
  input  logic [7:0]                   in_preload_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [7:0]                   out_next_pc,
  input  logic                         out_halted,
  input  logic [2:0]                   out_instr_class,
  input  logic                         out_reg_write_valid,
  input  logic [risc8_pkg::RIDX_W-1:0] out_reg_write_index,
  input  logic [7:0]                   out_reg_write_value,
  input  logic                         out_mem_write_valid,
  input  logic [7:0]                   out_mem_write_addr,
  input  logic [7:0]                   out_mem_write_value,
  output int                           fail_count,
  output int                           outstanding
);
  import risc8_pkg::*;

  logic [7:0] gpr [NUM_REGS];
  logic [7:0] dmem [DMEM_DEPTH];
  logic [7:0] pc;
  logic       halt_seen;
  result_t    predicted_retires [$];
  int         mismatches = 0;

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  function automatic result_t retire_item(input logic [1:0] req, input logic [15:0] iw,
                                          input logic [7:0] idx, input logic [7:0] val);
    result_t    r;
    logic [3:0] op, fa, fb, fc;
    logic [7:0] rb, rc, seq, ea, wdata;
    r = '0;
    r.instr_class = CLS_NONE;
    r.next_pc = pc;
    op = iw[15:12];
    fa = iw[11:8];
    fb = iw[7:4];
    fc = iw[3:0];
    case (req)
      REQ_PRELOAD_REG: begin
        if (idx < NUM_REGS) begin
          gpr[idx[3:0]] = val;
          r.reg_write_valid = 1'b1;
          r.reg_write_index = idx[3:0];
          r.reg_write_value = val;
        end
      end
      REQ_PRELOAD_MEM: begin
        if (idx < DMEM_DEPTH) begin
          dmem[idx] = val;
          r.mem_write_valid = 1'b1;
          r.mem_write_addr = idx;
          r.mem_write_value = val;
        end
      end
      REQ_EXEC: begin
        if (!halt_seen) begin
          rb = gpr[fb];
          rc = gpr[fc];
          seq = pc + 8'd2;
          ea = rb + {{4{fc[3]}}, fc};
          ea = 8'(ea % DMEM_DEPTH);
          wdata = '0;
          r.next_pc = seq;
          case (op)
            OP_ADD:   begin wdata = rb + rc;        r.instr_class = CLS_ARITH; end
            OP_SUB:   begin wdata = rb - rc;        r.instr_class = CLS_ARITH; end
            OP_MUL:   begin wdata = rb * rc;        r.instr_class = CLS_ARITH; end
            OP_INC:   begin wdata = gpr[fa] + 8'd1; r.instr_class = CLS_ARITH; end
            OP_AND:   begin wdata = rb & rc;        r.instr_class = CLS_LOGIC; end
            OP_OR:    begin wdata = rb | rc;        r.instr_class = CLS_LOGIC; end
            OP_NOT:   begin wdata = ~rb;            r.instr_class = CLS_LOGIC; end
            OP_XOR:   begin wdata = rb ^ rc;        r.instr_class = CLS_LOGIC; end
            OP_LOAD:  begin wdata = dmem[ea];       r.instr_class = CLS_DATA;  end
            OP_STORE: begin
              dmem[ea] = gpr[fa];
              r.instr_class = CLS_DATA;
              r.mem_write_valid = 1'b1;
              r.mem_write_addr = ea;
              r.mem_write_value = gpr[fa];
            end
            OP_JMP: begin
              r.instr_class = CLS_CTRL;
              r.next_pc = seq + {iw[10:4], 1'b0};
            end
            OP_BEQZ: begin
              r.instr_class = CLS_CTRL;
              if (gpr[fa] == 8'd0) r.next_pc = seq + {iw[6:0], 1'b0};
            end
            OP_HALT: begin
              r.instr_class = CLS_HALT;
              halt_seen = 1'b1;
            end
            default: r.instr_class = CLS_NONE;
          endcase
          if (op <= OP_LOAD) begin
            gpr[fa] = wdata;
            r.reg_write_valid = 1'b1;
            r.reg_write_index = fa;
            r.reg_write_value = wdata;
          end
          pc = r.next_pc;
        end
      end
      default: ;
    endcase
    r.halted = halt_seen;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got, want;
    if (!rst_n) begin
      pc = '0;
      halt_seen = 1'b0;
      predicted_retires.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_next_pc, out_halted, out_instr_class, out_reg_write_valid,
               out_reg_write_index, out_reg_write_value, out_mem_write_valid,
               out_mem_write_addr, out_mem_write_value};
        if (predicted_retires.size() == 0) begin
          $display("%0t: result item with none pending, expected none, actual %h",
                   $time, got);
          mismatches++;
        end else begin
          want = predicted_retires.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("halted", 8'(want.halted), 8'(got.halted));
          check_field("instr_class", 8'(want.instr_class), 8'(got.instr_class));
          check_field("reg_write_valid", 8'(want.reg_write_valid),
                      8'(got.reg_write_valid));
          check_field("reg_write_index", 8'(want.reg_write_index),
                      8'(got.reg_write_index));
          check_field("reg_write_value", want.reg_write_value, got.reg_write_value);
          check_field("mem_write_valid", 8'(want.mem_write_valid),
                      8'(got.mem_write_valid));
          check_field("mem_write_addr", want.mem_write_addr, got.mem_write_addr);
          check_field("mem_write_value", want.mem_write_value, got.mem_write_value);
        end
      end
      if (in_valid && !in_stall)
        predicted_retires.insert(predicted_retires.size(),
                                 retire_item(in_req_type, in_instr_word,
                                             in_preload_index, in_preload_value));
    end
    outstanding <= predicted_retires.size();
    fail_count <= mismatches;
  end

endmodule

FILE: tb/sv/eight_bit_risc_instruction_executor_test.sv
// ----------------------------------------------------------------------------
// eight_bit_risc_instruction_executor_test
// Loads every register and every data memory byte, runs directed instructions
// covering each opcode and the wrap, offset and no-op corners, then a random
// instruction stream, and closes with halt and the items that follow it.
// Sender gaps and result stalls change by phase; a checker scores each result.
// ----------------------------------------------------------------------------
module eight_bit_risc_instruction_executor_test;
  import risc8_pkg::*;

  localparam int DMEM_DEPTH   = 256;
  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT  = 100000;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_req_type;
  logic [15:0]         in_instr_word;
  logic [7:0]          in_preload_index;
  logic [7:0]          in_preload_value;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          out_next_pc;
  logic                out_halted;
  logic [2:0]          out_instr_class;
  logic                out_reg_write_valid;
  logic [RIDX_W-1:0]   out_reg_write_index;
  logic [7:0]          out_reg_write_value;
  logic                out_mem_write_valid;
  logic [7:0]          out_mem_write_addr;
  logic [7:0]          out_mem_write_value;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int sent_total = 0;
  int sent_exec = 0;
  int sent_preload = 0;
  int sent_unknown = 0;

  eight_bit_risc_instruction_executor #(.DMEM_DEPTH(DMEM_DEPTH)) dut (.*);

  eight_bit_risc_instruction_executor_checker #(.DMEM_DEPTH(DMEM_DEPTH)) retire_check (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("eight_bit_risc_instruction_executor test failed");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic logic [15:0] instr(input logic [3:0] op, input logic [3:0] a,
                                        input logic [3:0] b, input logic [3:0] c);
    return {op, a, b, c};
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [15:0] iw,
                           input logic [7:0] idx, input logic [7:0] val);
    if (sent_total % 50 == 0) begin
      case ((sent_total / 50) % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 54; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 54; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
    end
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_instr_word <= iw;
    in_preload_index <= idx;
    in_preload_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    if (req == REQ_EXEC) sent_exec++;
    else if (req == REQ_PRELOAD_REG || req == REQ_PRELOAD_MEM) sent_preload++;
    else sent_unknown++;
  endtask

  task automatic send_exec(input logic [15:0] iw);
    send_item(REQ_EXEC, iw, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_other(input logic [1:0] req, input logic [7:0] idx,
                            input logic [7:0] val);
    send_item(req, 16'($urandom_range(65535)), idx, val);
  endtask

  initial begin
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_req_type = REQ_EXEC;
    in_instr_word = '0;
    in_preload_index = '0;
    in_preload_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_other(REQ_PRELOAD_REG, 8'd0, 8'h00);
    send_other(REQ_PRELOAD_REG, 8'd1, 8'hFF);
    send_other(REQ_PRELOAD_REG, 8'd2, 8'h80);
    send_other(REQ_PRELOAD_REG, 8'd3, 8'h7F);
    send_other(REQ_PRELOAD_REG, 8'd4, 8'h01);
    for (int r = 5; r < NUM_REGS; r++)
      send_other(REQ_PRELOAD_REG, 8'(r), 8'($urandom_range(255)));
    send_other(REQ_PRELOAD_REG, 8'd16, 8'($urandom_range(255)));
    send_other(REQ_PRELOAD_REG, 8'd255, 8'($urandom_range(255)));
    send_other(REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
    for (int a = 0; a < DMEM_DEPTH; a++)
      send_other(REQ_PRELOAD_MEM, 8'(a), 8'($urandom_range(255)));

    send_exec(instr(OP_ADD, 4'd5, 4'd1, 4'd4));
    send_exec(instr(OP_SUB, 4'd6, 4'd0, 4'd4));
    send_exec(instr(OP_MUL, 4'd7, 4'd2, 4'd1));
    send_exec(instr(OP_MUL, 4'd8, 4'd3, 4'd3));
    send_exec(instr(OP_LOAD, 4'd9, 4'd1, 4'd7));
    send_exec(instr(OP_LOAD, 4'd10, 4'd0, 4'd8));
    send_exec(instr(OP_STORE, 4'd3, 4'd1, 4'd7));
    send_exec(instr(OP_LOAD, 4'd11, 4'd1, 4'd7));
    send_exec(instr(OP_AND, 4'd12, 4'd1, 4'd2));
    send_exec(instr(OP_OR, 4'd13, 4'd2, 4'd3));
    send_exec(instr(OP_NOT, 4'd14, 4'd0, 4'd0));
    send_exec(instr(OP_XOR, 4'd15, 4'd1, 4'd3));
    send_exec(instr(OP_INC, 4'd1, 4'($urandom_range(15)), 4'($urandom_range(15))));
    send_exec(instr(OP_INC, 4'd3, 4'($urandom_range(15)), 4'($urandom_range(15))));
    for (int op = 12; op < 15; op++)
      send_exec({4'(op), 12'($urandom_range(4095))});
    send_exec({OP_BEQZ, 4'd0, 8'h80});
    send_exec({OP_BEQZ, 4'd4, 8'h7F});
    send_exec({OP_JMP, 8'h7F, 4'($urandom_range(15))});
    send_exec({OP_JMP, 8'h80, 4'($urandom_range(15))});

    // halt is kept for the end: nothing executes after it
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 82)
        send_exec({4'($urandom_range(14)), 12'($urandom_range(4095))});
      else if (pick < 90)
        send_other(REQ_PRELOAD_REG,
                   8'(($urandom_range(3) != 0) ? $urandom_range(15) : $urandom_range(255)),
                   8'($urandom_range(255)));
      else if (pick < 97)
        send_other(REQ_PRELOAD_MEM, 8'($urandom_range(255)), 8'($urandom_range(255)));
      else
        send_other(REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end

    send_exec(instr(OP_HALT, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    4'($urandom_range(15))));
    repeat (3) send_exec(16'($urandom_range(65535)));
    send_other(REQ_PRELOAD_REG, 8'($urandom_range(15)), 8'($urandom_range(255)));
    send_other(REQ_PRELOAD_MEM, 8'($urandom_range(255)), 8'($urandom_range(255)));
    send_other(REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
    send_exec(instr(OP_HALT, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    4'($urandom_range(15))));

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d instructions, %0d preloads and %0d unknown requests in %0d cycles,",
             sent_exec, sent_preload, sent_unknown, cycles);
    $display("across gap and stall phases, ending with halt and the items after it.");
    if (fail_count == 0)
      $display("eight_bit_risc_instruction_executor test passed");
    else
      $display("eight_bit_risc_instruction_executor test failed");
    $finish;
  end

endmodule
